FILE: design/lrupr_pkg.sv
`timescale 1ns / 1ps

package lrupr_pkg;

    localparam int CFG_BITS   = 4;
    localparam int FRAME_BITS = 3;

    localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

endpackage

FILE: design/lrupr_if.sv
`timescale 1ns / 1ps

interface lrupr_req_if #(
    parameter int PAGE_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

interface lrupr_rsp_if #(
    parameter int PAGE_BITS = 16
);
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic [lrupr_pkg::FRAME_BITS-1:0]    frame;
    logic                                evicted_valid;
    logic [PAGE_BITS-1:0]                evicted_page;

    modport source (output valid, output hit, output frame, output evicted_valid,
                    output evicted_page, input ready);
    modport sink   (input valid, input hit, input frame, input evicted_valid,
                    input evicted_page, output ready);
endinterface

FILE: design/lru_page_replacement.sv
// a reference is captured in idle, its frames are scanned, then the update registers the result beat
// a miss scans all F active frames, a hit stops at the matching frame (index + 1)
// one frame is looked up per cycle by the shared page compare and age scan unit
// one item in flight at a time: a new reference is taken only once the result beat is accepted
// synchronous active-low reset clears valid bits, ages, state and the frame count r_cfg (to 8)
// frame page contents are not cleared and are only read behind a set valid bit
`timescale 1ns / 1ps

module lru_page_replacement #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lrupr_pkg::CFG_BITS-1:0] i_cfg_wdata,
    lrupr_req_if.sink                      i_req,
    lrupr_rsp_if.source                    o_rsp
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int AW = IW;
    localparam logic [AW-1:0] AGE_MAX = AW'(MAX_FRAMES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_OUT
    } t_state;

    t_state                           r_state;
    logic [lrupr_pkg::CFG_BITS-1:0]   r_cfg;
    logic [PAGE_BITS-1:0]             r_page;
    logic [IW-1:0]                    r_cnt;
    logic [IW-1:0]                    r_last;
    logic                             r_found;
    logic [IW-1:0]                    r_hit_idx;
    logic [AW-1:0]                    r_hit_age;
    logic                             r_empty;
    logic [IW-1:0]                    r_empty_idx;
    logic [IW-1:0]                    r_old_idx;
    logic [AW-1:0]                    r_old_age;
    logic [PAGE_BITS-1:0]             r_old_page;
    logic [MAX_FRAMES-1:0]            r_valid;
    logic [AW-1:0]                    r_age   [MAX_FRAMES];
    logic [PAGE_BITS-1:0]             r_pages [MAX_FRAMES];

    logic                             r_out_valid;
    logic                             r_out_hit;
    logic [lrupr_pkg::FRAME_BITS-1:0] r_out_frame;
    logic                             r_out_ev_valid;
    logic [PAGE_BITS-1:0]             r_out_ev_page;

    int unsigned                      w_eff;
    logic [IW-1:0]                    w_last;
    logic                             w_match;
    logic                             w_fill;
    logic [IW-1:0]                    w_sel;
    logic [AW-1:0]                    w_sel_age;
    logic [AW-1:0]                    n_age   [MAX_FRAMES];

    // clamp the frame count to 1 .. MAX_FRAMES
    always_comb begin
        w_eff = 32'(r_cfg);
        if (w_eff < 1) begin
            w_eff = 1;
        end
        if (w_eff > MAX_FRAMES) begin
            w_eff = MAX_FRAMES;
        end
        w_last = IW'(w_eff - 1);
    end

    // shared compare unit: one frame per cycle
    assign w_match = r_valid[r_cnt] && (r_pages[r_cnt] == r_page);

    always_comb begin
        w_fill = 1'b0;
        if (r_found) begin
            w_sel     = r_hit_idx;
            w_sel_age = r_hit_age;
        end else if (r_empty) begin
            w_sel     = r_empty_idx;
            w_sel_age = '0;
            w_fill    = 1'b1;
        end else begin
            w_sel     = r_old_idx;
            w_sel_age = r_old_age;
        end
        for (int k = 0; k < MAX_FRAMES; k++) begin
            n_age[k] = r_age[k];
            if (IW'(k) == w_sel) begin
                n_age[k] = '0;
            end else if (w_fill) begin
                if (r_valid[k] && (r_age[k] < AGE_MAX)) begin
                    n_age[k] = r_age[k] + 1'b1;
                end
            end else if (r_valid[k] && (r_age[k] < w_sel_age)) begin
                n_age[k] = r_age[k] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= lrupr_pkg::CFG_RESET;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_FRAMES; k++) begin
                r_age[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_page  <= i_req.page;
                        r_cnt   <= '0;
                        r_last  <= w_last;
                        r_found <= 1'b0;
                        r_empty <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // oldest frame, lowest index on ties
                    if ((r_cnt == '0) || (r_age[r_cnt] > r_old_age)) begin
                        r_old_idx  <= r_cnt;
                        r_old_age  <= r_age[r_cnt];
                        r_old_page <= r_pages[r_cnt];
                    end
                    if (!r_valid[r_cnt] && !r_empty) begin
                        r_empty     <= 1'b1;
                        r_empty_idx <= r_cnt;
                    end
                    if (w_match) begin
                        r_found   <= 1'b1;
                        r_hit_idx <= r_cnt;
                        r_hit_age <= r_age[r_cnt];
                        r_state   <= S_UPDATE;
                    end else if (r_cnt == r_last) begin
                        r_state <= S_UPDATE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_UPDATE: begin
                    for (int k = 0; k < MAX_FRAMES; k++) begin
                        r_age[k] <= n_age[k];
                    end
                    if (!r_found) begin
                        r_pages[w_sel] <= r_page;
                        r_valid[w_sel] <= 1'b1;
                    end
                    r_out_valid    <= 1'b1;
                    r_out_hit      <= r_found;
                    r_out_frame    <= lrupr_pkg::FRAME_BITS'(w_sel);
                    r_out_ev_valid <= !r_found && !r_empty;
                    r_out_ev_page  <= (!r_found && !r_empty) ? r_old_page : '0;
                    r_state        <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out_hit;
    assign o_rsp.frame         = r_out_frame;
    assign o_rsp.evicted_valid = r_out_ev_valid;
    assign o_rsp.evicted_page  = r_out_ev_page;

    // never take a new reference while a result beat is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("input ready while result pending");

    // a delivered result frees the block for the next reference
    a_out_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready) |=> i_req.ready)
        else $error("block not ready after result beat");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.hit) |-> !o_rsp.evicted_valid)
        else $error("eviction reported on a hit");

    // evicted page reads zero unless something was replaced
    a_ev_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.evicted_valid) |-> (o_rsp.evicted_page == '0))
        else $error("nonzero evicted page without eviction");

    // the reported frame is always resident after the update
    a_frame_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> r_valid[$past(w_sel)])
        else $error("reported frame not valid");

endmodule

FILE: sim/lru_page_replacement_tb.sv
`timescale 1ns / 1ps

module lru_page_replacement_tb;

    localparam int MAX_FRAMES    = 8;
    localparam int PAGE_BITS     = 16;
    localparam int POOL_SIZE     = 12;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = MAX_FRAMES + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PRINT_LIMIT   = 200;

    // frame count per random phase, phase 0 in the low nibble
    localparam logic [NUM_PHASES*lrupr_pkg::CFG_BITS-1:0] FRAME_SETTINGS = {
        4'd8, 4'd6, 4'd4, 4'd7, 4'd9, 4'd2, 4'd15, 4'd5, 4'd0, 4'd3, 4'd8, 4'd1
    };

    typedef struct packed {
        logic                             hit;
        logic [lrupr_pkg::FRAME_BITS-1:0] frame;
        logic                             evicted_valid;
        logic [PAGE_BITS-1:0]             evicted_page;
    } t_lru_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [lrupr_pkg::CFG_BITS-1:0] i_cfg_wdata;

    lrupr_req_if #(.PAGE_BITS(PAGE_BITS)) req_if ();
    lrupr_rsp_if #(.PAGE_BITS(PAGE_BITS)) rsp_if ();

    lru_page_replacement #(
        .MAX_FRAMES(MAX_FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // frame table as the block should hold it
    logic [PAGE_BITS-1:0]           mdl_page  [MAX_FRAMES];
    logic                           mdl_valid [MAX_FRAMES];
    int unsigned                    mdl_age   [MAX_FRAMES];
    logic [lrupr_pkg::CFG_BITS-1:0] mdl_frames_cfg;

    logic [PAGE_BITS-1:0] page_refs_q[$];
    t_lru_result          frame_results_q[$];
    logic [PAGE_BITS-1:0] page_pool[POOL_SIZE];

    int refs_queued   = 0;
    int refs_accepted = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    always #6 i_clk = ~i_clk;

    function automatic void make_recent(int unsigned idx);
        int unsigned old_age;
        int          k;
        old_age = mdl_age[idx];
        for (k = 0; k < MAX_FRAMES; k++) begin
            if (k != idx && mdl_valid[k] && mdl_age[k] < old_age)
                mdl_age[k]++;
        end
        mdl_age[idx] = 0;
    endfunction

    function automatic t_lru_result lru_reference(logic [PAGE_BITS-1:0] pg);
        t_lru_result res;
        int unsigned nf;
        int unsigned idx;
        int unsigned oldest;
        bit          found;
        bit          empty;
        int          k;
        res    = '0;
        idx    = 0;
        found  = 1'b0;
        empty  = 1'b0;
        nf     = (mdl_frames_cfg == 0) ? 1 :
                 (mdl_frames_cfg > MAX_FRAMES) ? MAX_FRAMES : mdl_frames_cfg;
        // lowest matching index wins when a page sits in two frames
        for (k = 0; k < nf && !found; k++) begin
            if (mdl_valid[k] && mdl_page[k] == pg) begin
                idx   = k;
                found = 1'b1;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            make_recent(idx);
        end else begin
            for (k = 0; k < nf && !empty; k++) begin
                if (!mdl_valid[k]) begin
                    idx   = k;
                    empty = 1'b1;
                end
            end
            if (empty) begin
                // fill ages every valid frame, inactive ones too, saturating
                for (k = 0; k < MAX_FRAMES; k++) begin
                    if (mdl_valid[k] && mdl_age[k] < MAX_FRAMES - 1)
                        mdl_age[k]++;
                end
                mdl_valid[idx] = 1'b1;
                mdl_page[idx]  = pg;
                mdl_age[idx]   = 0;
            end else begin
                oldest = 0;
                idx    = 0;
                for (k = 0; k < nf; k++) begin
                    if (mdl_age[k] > oldest) begin
                        oldest = mdl_age[k];
                        idx    = k;
                    end
                end
                res.evicted_valid = 1'b1;
                res.evicted_page  = mdl_page[idx];
                mdl_page[idx]     = pg;
                make_recent(idx);
            end
        end
        res.frame = lrupr_pkg::FRAME_BITS'(idx);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_page(input logic [PAGE_BITS-1:0] pg);
        page_refs_q.push_back(pg);
        refs_queued++;
    endtask

    task automatic set_frames(input logic [lrupr_pkg::CFG_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mdl_frames_cfg = value;
    endtask

    task automatic wait_idle();
        while (refs_accepted != refs_queued || frame_results_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // request driver: valid holds until the beat is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.page  <= '0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) begin
                frame_results_q.push_back(lru_reference(req_if.page));
                refs_accepted++;
            end
            if (page_refs_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                req_if.valid <= 1'b1;
                req_if.page  <= page_refs_q.pop_front();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // response monitor and ready generator
    always @(posedge i_clk) begin : result_check
        t_lru_result want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                results_seen++;
                if (frame_results_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d beat with nothing pending",
                                              results_seen));
                end else begin
                    want = frame_results_q.pop_front();
                    if (rsp_if.hit !== want.hit)
                        report_mismatch($sformatf("result %0d hit: got %b, expected %b",
                                                  results_seen, rsp_if.hit, want.hit));
                    if (rsp_if.frame !== want.frame)
                        report_mismatch($sformatf("result %0d frame: got %0d, expected %0d",
                                                  results_seen, rsp_if.frame, want.frame));
                    if (rsp_if.evicted_valid !== want.evicted_valid)
                        report_mismatch($sformatf(
                            "result %0d evicted_valid: got %b, expected %b",
                            results_seen, rsp_if.evicted_valid, want.evicted_valid));
                    if (rsp_if.evicted_page !== want.evicted_page)
                        report_mismatch($sformatf(
                            "result %0d evicted_page: got %h, expected %h",
                            results_seen, rsp_if.evicted_page, want.evicted_page));
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** lru_page_replacement: FAILED **");
            $finish;
        end
    end

    initial begin
        int                             phase;
        int                             n;
        int                             roll;
        int                             eff;
        int                             pick_hi;
        logic [lrupr_pkg::CFG_BITS-1:0] setting;
        logic [PAGE_BITS-1:0]           pg;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        req_if.valid = 1'b0;
        req_if.page  = '0;
        rsp_if.ready = 1'b0;
        mdl_frames_cfg = lrupr_pkg::CFG_RESET;
        for (n = 0; n < MAX_FRAMES; n++) begin
            mdl_page[n]  = '0;
            mdl_valid[n] = 1'b0;
            mdl_age[n]   = 0;
        end
        for (n = 0; n < POOL_SIZE; n++)
            page_pool[n] = PAGE_BITS'($urandom);
        send_idle_pct = 38;
        recv_idle_pct = 87;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset frame count: fill all frames, hit, then evict the oldest
        queue_page(16'h0000);
        queue_page(16'hFFFF);
        queue_page(16'h1234);
        queue_page(16'h8001);
        queue_page(16'h00AA);
        queue_page(16'h5555);
        queue_page(16'hAAAA);
        queue_page(16'h7FFE);
        queue_page(16'hFFFF);
        queue_page(16'h0000);
        queue_page(16'h4321);
        queue_page(16'h4321);
        wait_idle();

        // shrink: a page held above the active range must miss
        set_frames(4'd2);
        queue_page(16'hAAAA);
        queue_page(16'h0000);
        wait_idle();

        // grow again: the page now sits in two frames
        set_frames(4'd8);
        queue_page(16'hAAAA);
        wait_idle();

        // zero acts as one frame
        set_frames(4'd0);
        queue_page(16'hBEEF);
        queue_page(16'hBEEF);
        wait_idle();

        // above the frame count acts as the full set
        set_frames(4'd15);
        queue_page(16'h0F0F);
        wait_idle();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            send_idle_pct = (phase < 4) ? 38 : (phase < 8) ? 87 : 0;
            recv_idle_pct = (phase < 4) ? 87 : (phase < 8) ? 38 : 0;
            setting = FRAME_SETTINGS[phase*lrupr_pkg::CFG_BITS +: lrupr_pkg::CFG_BITS];
            set_frames(setting);
            eff     = (setting == 0) ? 1 : (setting > MAX_FRAMES) ? MAX_FRAMES : setting;
            pick_hi = (eff + 3 > POOL_SIZE - 1) ? POOL_SIZE - 1 : eff + 3;
            for (n = 0; n < 3; n++)
                page_pool[$urandom_range(0, POOL_SIZE - 1)] = PAGE_BITS'($urandom);
            // long receiver stall while the whole phase is on offer
            if (phase == 1)
                hold_req++;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 6 && n == PHASE_ITEMS / 2)
                    wait_idle();
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    pg = page_pool[$urandom_range(0, pick_hi)];
                else if (roll < 92)
                    pg = PAGE_BITS'($urandom);
                else
                    pg = roll[0] ? '1 : '0;
                queue_page(pg);
            end
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("** lru_page_replacement: PASSED **");
        end else begin
            $display("** lru_page_replacement: FAILED **");
        end
        $finish;
    end

endmodule
